// ===== rtl/cube_heightmap_bilinear_sampler_assert.svh =====
// Assertion macros for the sampler blocks
`ifndef CUBE_HEIGHTMAP_BILINEAR_SAMPLER_ASSERT_SVH
`define CUBE_HEIGHTMAP_BILINEAR_SAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
`define CHBS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CHBS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CHBS_ASSERT_IMP(lbl, ante, cons, msg)
`define CHBS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/chbs_pkg.sv =====
package chbs_pkg;

    localparam int MAX_SIDE_DEF    = 64;
    localparam int MAX_LEVELS_DEF  = 7;
    localparam int STORE_DEPTH_DEF = 32766;
    localparam int CMD_Q_DEPTH     = 2;
    localparam int RES_Q_DEPTH     = 2;

    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int COORD_W  = 17;
    localparam int FRAC_W   = 16;
    localparam int H_W      = 8 + COORD_W;
    localparam int ACC_W    = H_W + COORD_W;
    localparam int RES_LSB  = 2 * FRAC_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOD_COUNT   = 2'd2;

    localparam logic [CFG_W-1:0] BASE_WIDTH_RST  = 7'd64;
    localparam logic [CFG_W-1:0] BASE_HEIGHT_RST = 7'd64;
    localparam logic [2:0]       LOD_COUNT_RST   = 3'd7;

    localparam logic             KIND_SAMPLE = 1'b1;
    localparam logic [2:0]       FACE_COUNT  = 3'd6;
    localparam logic [COORD_W-1:0] ONE_Q16   = 17'h10000;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SAMPLE,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               load_start;
        logic [7:0]         texel_byte;
        logic [2:0]         face;
        logic [2:0]         level;
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
    } t_cmd;

    typedef struct packed {
        logic [7:0] height;
        logic       bad_request;
    } t_res;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_OFFS,
        BK_COORD,
        BK_PREP,
        BK_ADDR,
        BK_READ,
        BK_ACC,
        BK_VERT0,
        BK_VERT1,
        BK_DONE
    } t_back_state;

endpackage

// ===== rtl/chbs_fifo.sv =====
`include "cube_heightmap_bilinear_sampler_assert.svh"

module chbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = chbs_pkg::CMD_Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `CHBS_ASSERT_NXT(a_count_track, do_push && !do_pop, r_count == $past(r_count) + 1'b1, "queue count missed a push")
    `CHBS_ASSERT_NXT(a_pop_track, do_pop && !do_push, r_count == $past(r_count) - 1'b1, "queue count missed a pop")

endmodule

// ===== rtl/chbs_front.sv =====
module chbs_front #(
    parameter int MAX_SIDE   = chbs_pkg::MAX_SIDE_DEF,
    parameter int MAX_LEVELS = chbs_pkg::MAX_LEVELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [chbs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [chbs_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_push,
    input  logic                           i_q_full,
    input  logic                           i_kind,
    input  logic [7:0]                     i_texel_byte,
    input  logic                           i_load_start,
    input  logic [2:0]                     i_face,
    input  logic [2:0]                     i_level,
    input  logic [chbs_pkg::COORD_W-1:0]   i_u_coord,
    input  logic [chbs_pkg::COORD_W-1:0]   i_v_coord,
    output logic                           o_q_push,
    output chbs_pkg::t_cmd                 o_cmd,
    output logic [$clog2(MAX_SIDE+1)-1:0]  o_width,
    output logic [$clog2(MAX_SIDE+1)-1:0]  o_height
);

    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int LW = $clog2(MAX_LEVELS + 1);

    logic [chbs_pkg::CFG_W-1:0] r_base_width, n_base_width;
    logic [chbs_pkg::CFG_W-1:0] r_base_height, n_base_height;
    logic [2:0]                 r_lod_count, n_lod_count;

    logic [SW-1:0] w_sat, h_sat;
    logic [LW-1:0] lods;
    logic          level_ok, bad;

    always_comb begin
        n_base_width  = r_base_width;
        n_base_height = r_base_height;
        n_lod_count   = r_lod_count;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                chbs_pkg::CFG_BASE_WIDTH:  n_base_width  = i_cfg_data;
                chbs_pkg::CFG_BASE_HEIGHT: n_base_height = i_cfg_data;
                chbs_pkg::CFG_LOD_COUNT:   n_lod_count   = i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_width  <= chbs_pkg::BASE_WIDTH_RST;
            r_base_height <= chbs_pkg::BASE_HEIGHT_RST;
            r_lod_count   <= chbs_pkg::LOD_COUNT_RST;
        end else begin
            r_base_width  <= n_base_width;
            r_base_height <= n_base_height;
            r_lod_count   <= n_lod_count;
        end
    end

    // saturated sizes and usable level count
    always_comb begin
        w_sat = (32'(r_base_width) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(r_base_width);
        h_sat = (32'(r_base_height) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(r_base_height);
        lods  = (32'(r_lod_count) > 32'(MAX_LEVELS)) ? LW'(MAX_LEVELS) : LW'(r_lod_count);
    end

    assign level_ok = (32'(i_level) < 32'(lods));
    assign bad = (i_face >= chbs_pkg::FACE_COUNT) || !level_ok
              || ((w_sat >> i_level) == '0) || ((h_sat >> i_level) == '0);

    always_comb begin
        o_cmd.op         = (i_kind == chbs_pkg::KIND_SAMPLE)
                         ? (bad ? chbs_pkg::OP_BAD : chbs_pkg::OP_SAMPLE)
                         : chbs_pkg::OP_LOAD;
        o_cmd.load_start = i_load_start;
        o_cmd.texel_byte = i_texel_byte;
        o_cmd.face       = i_face;
        o_cmd.level      = i_level;
        o_cmd.u          = (i_u_coord > chbs_pkg::ONE_Q16) ? chbs_pkg::ONE_Q16 : i_u_coord;
        o_cmd.v          = (i_v_coord > chbs_pkg::ONE_Q16) ? chbs_pkg::ONE_Q16 : i_v_coord;
    end

    assign o_q_push = i_push && !i_q_full;
    assign o_width  = w_sat;
    assign o_height = h_sat;

endmodule

// ===== rtl/chbs_back.sv =====
`include "cube_heightmap_bilinear_sampler_assert.svh"

module chbs_back #(
    parameter int MAX_SIDE    = chbs_pkg::MAX_SIDE_DEF,
    parameter int STORE_DEPTH = chbs_pkg::STORE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(MAX_SIDE+1)-1:0] i_width,
    input  logic [$clog2(MAX_SIDE+1)-1:0] i_height,
    input  chbs_pkg::t_cmd                i_cmd,
    input  logic                          i_cmd_empty,
    output logic                          o_cmd_pop,
    input  logic                          i_res_full,
    output logic                          o_res_push,
    output chbs_pkg::t_res                o_res
);

    localparam int SW     = $clog2(MAX_SIDE + 1);
    localparam int SC     = SW + 2;
    localparam int AREA_W = 2 * SW;
    localparam int ADDR_W = $clog2(8 * MAX_SIDE * MAX_SIDE);
    localparam int AW     = $clog2(STORE_DEPTH);
    localparam int PTR_W  = $clog2(STORE_DEPTH + 1);
    localparam int CRD_W  = chbs_pkg::COORD_W;
    localparam int FR_W   = chbs_pkg::FRAC_W;
    localparam int H_W    = chbs_pkg::H_W;
    localparam int ACC_W  = chbs_pkg::ACC_W;

    localparam logic signed [SC-1:0] ONE_S = SC'(1);
    localparam logic signed [SC-1:0] TWO_S = SC'(2);

    function automatic logic [SW-1:0] clamp_coord(input logic signed [SC-1:0] c,
                                                  input logic [SW-1:0] lim);
        logic [SW-1:0] res;
        if (c[SC-1]) begin
            res = '0;
        end else if (c >= signed'({2'b00, lim})) begin
            res = lim - 1'b1;
        end else begin
            res = c[SW-1:0];
        end
        return res;
    endfunction

    chbs_pkg::t_back_state r_state, n_state;

    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic [7:0]        r_mem [STORE_DEPTH];
    logic [7:0]        r_rdata;
    logic [AW-1:0]     r_rd_addr;
    logic              r_oob;

    logic [2:0]        r_face, r_level, r_lvl;
    logic [CRD_W-1:0]  r_u, r_v;
    logic [SW-1:0]     r_wl, r_hl;
    logic [ADDR_W-1:0] r_base;
    logic [SW-1:0]     r_px, r_py;
    logic [FR_W-1:0]   r_fx, r_fy;
    logic [SW-1:0]     r_cx [4];
    logic [SW-1:0]     r_cy [4];
    logic [1:0]        r_k;
    logic [H_W-1:0]    r_h0, r_h1;
    logic [ACC_W-1:0]  r_acc;
    logic [7:0]        r_height;
    logic              r_bad;

    logic              mem_we, can_write;
    logic [PTR_W-1:0]  eff_ptr;
    logic [AREA_W-1:0] area, row_off;
    logic [ADDR_W-1:0] area_x, six_area, face_area, addr;
    logic [CRD_W+SW-1:0] xprod, yprod;
    logic              flip_x, flip_y, oob;
    logic signed [SC-1:0] px_s, py_s;
    logic signed [SC-1:0] sx [4];
    logic signed [SC-1:0] sy [4];
    logic [7:0]        texel;
    logic [CRD_W-1:0]  gx, gy, fx17, fy17, weight;
    logic [H_W-1:0]    tprod;
    logic [ACC_W-1:0]  vsum;

    // load pointer
    assign eff_ptr   = i_cmd.load_start ? '0 : r_ptr;
    assign can_write = (32'(eff_ptr) < 32'(STORE_DEPTH));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            chbs_pkg::BK_IDLE: begin
                if (!i_cmd_empty) begin
                    case (i_cmd.op)
                        chbs_pkg::OP_SAMPLE: n_state = chbs_pkg::BK_OFFS;
                        chbs_pkg::OP_BAD:    n_state = chbs_pkg::BK_DONE;
                        default:             n_state = chbs_pkg::BK_IDLE;
                    endcase
                end
            end
            chbs_pkg::BK_OFFS: begin
                if (r_lvl == r_level) begin
                    n_state = chbs_pkg::BK_COORD;
                end
            end
            chbs_pkg::BK_COORD: n_state = chbs_pkg::BK_PREP;
            chbs_pkg::BK_PREP:  n_state = chbs_pkg::BK_ADDR;
            chbs_pkg::BK_ADDR:  n_state = chbs_pkg::BK_READ;
            chbs_pkg::BK_READ:  n_state = chbs_pkg::BK_ACC;
            chbs_pkg::BK_ACC: begin
                n_state = (r_k == 2'd3) ? chbs_pkg::BK_VERT0 : chbs_pkg::BK_ADDR;
            end
            chbs_pkg::BK_VERT0: n_state = chbs_pkg::BK_VERT1;
            chbs_pkg::BK_VERT1: n_state = chbs_pkg::BK_DONE;
            chbs_pkg::BK_DONE: begin
                if (!i_res_full) begin
                    n_state = chbs_pkg::BK_IDLE;
                end
            end
            default: n_state = chbs_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        mem_we     = 1'b0;
        n_ptr      = r_ptr;
        case (r_state)
            chbs_pkg::BK_IDLE: begin
                o_cmd_pop = !i_cmd_empty;
                if (!i_cmd_empty && (i_cmd.op == chbs_pkg::OP_LOAD)) begin
                    mem_we = can_write;
                    n_ptr  = can_write ? eff_ptr + 1'b1 : eff_ptr;
                end
            end
            chbs_pkg::BK_DONE: o_res_push = !i_res_full;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chbs_pkg::BK_IDLE;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
        end
    end

    // texel memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[AW'(eff_ptr)] <= i_cmd.texel_byte;
        end
        r_rdata <= r_mem[r_rd_addr];
    end

    // mip and face offset, one level per cycle
    assign area      = AREA_W'(r_wl) * AREA_W'(r_hl);
    assign area_x    = ADDR_W'(area);
    assign six_area  = (area_x << 2) + (area_x << 1);
    assign face_area = (r_face[0] ? area_x : '0)
                     + (r_face[1] ? (area_x << 1) : '0)
                     + (r_face[2] ? (area_x << 2) : '0);

    assign xprod = (CRD_W+SW)'(r_u) * (CRD_W+SW)'(r_wl);
    assign yprod = (CRD_W+SW)'(r_v) * (CRD_W+SW)'(r_hl);

    // edge substitution
    assign px_s   = signed'({2'b00, r_px});
    assign py_s   = signed'({2'b00, r_py});
    assign flip_x = ((SW+1)'(r_px) + (SW+1)'(1)) >= (SW+1)'(r_wl);
    assign flip_y = ((SW+1)'(r_py) + (SW+1)'(1)) >= (SW+1)'(r_hl);

    always_comb begin
        case ({flip_x, flip_y})
            2'b00: begin
                sx[0] = px_s;         sy[0] = py_s;
                sx[1] = px_s + ONE_S; sy[1] = py_s;
                sx[2] = px_s;         sy[2] = py_s + ONE_S;
                sx[3] = px_s + ONE_S; sy[3] = py_s + ONE_S;
            end
            2'b10: begin
                sx[0] = px_s - ONE_S; sy[0] = py_s;
                sx[1] = px_s - ONE_S; sy[1] = py_s;
                sx[2] = px_s - ONE_S; sy[2] = py_s + ONE_S;
                sx[3] = px_s - ONE_S; sy[3] = py_s + ONE_S;
            end
            2'b01: begin
                sx[0] = px_s;         sy[0] = py_s - ONE_S;
                sx[1] = px_s;         sy[1] = py_s - ONE_S;
                sx[2] = px_s + ONE_S; sy[2] = py_s - ONE_S;
                sx[3] = px_s + ONE_S; sy[3] = py_s - ONE_S;
            end
            default: begin
                sx[0] = px_s - ONE_S; sy[0] = py_s - ONE_S;
                sx[1] = px_s - ONE_S; sy[1] = py_s - ONE_S;
                sx[2] = px_s - TWO_S; sy[2] = py_s - TWO_S;
                sx[3] = px_s - TWO_S; sy[3] = py_s - TWO_S;
            end
        endcase
    end

    // fetch address
    assign row_off = AREA_W'(r_cy[r_k]) * AREA_W'(r_wl);
    assign addr    = r_base + ADDR_W'(row_off) + ADDR_W'(r_cx[r_k]);
    assign oob     = (32'(addr) >= 32'(STORE_DEPTH));

    // blend
    assign texel  = r_oob ? 8'd0 : r_rdata;
    assign fx17   = {1'b0, r_fx};
    assign fy17   = {1'b0, r_fy};
    assign gx     = chbs_pkg::ONE_Q16 - fx17;
    assign gy     = chbs_pkg::ONE_Q16 - fy17;
    assign weight = r_k[0] ? fx17 : gx;
    assign tprod  = H_W'(texel) * H_W'(weight);
    assign vsum   = r_acc + ACC_W'(r_h1) * ACC_W'(fy17);

    always_ff @(posedge i_clk) begin
        case (r_state)
            chbs_pkg::BK_IDLE: begin
                if (o_cmd_pop) begin
                    r_face   <= i_cmd.face;
                    r_level  <= i_cmd.level;
                    r_u      <= i_cmd.u;
                    r_v      <= i_cmd.v;
                    r_wl     <= i_width;
                    r_hl     <= i_height;
                    r_lvl    <= '0;
                    r_base   <= '0;
                    r_k      <= '0;
                    r_bad    <= (i_cmd.op == chbs_pkg::OP_BAD);
                    r_height <= '0;
                end
            end
            chbs_pkg::BK_OFFS: begin
                if (r_lvl == r_level) begin
                    r_base <= r_base + face_area;
                end else begin
                    r_base <= r_base + six_area;
                    r_wl   <= r_wl >> 1;
                    r_hl   <= r_hl >> 1;
                    r_lvl  <= r_lvl + 3'd1;
                end
            end
            chbs_pkg::BK_COORD: begin
                r_px <= xprod[FR_W +: SW];
                r_fx <= xprod[FR_W-1:0];
                r_py <= yprod[FR_W +: SW];
                r_fy <= yprod[FR_W-1:0];
            end
            chbs_pkg::BK_PREP: begin
                for (int i = 0; i < 4; i++) begin
                    r_cx[i] <= clamp_coord(sx[i], r_wl);
                    r_cy[i] <= clamp_coord(sy[i], r_hl);
                end
            end
            chbs_pkg::BK_ADDR: begin
                r_rd_addr <= AW'(addr);
                r_oob     <= oob;
            end
            chbs_pkg::BK_ACC: begin
                if (!r_k[1]) begin
                    r_h0 <= (r_k[0] ? r_h0 : '0) + tprod;
                end else begin
                    r_h1 <= (r_k[0] ? r_h1 : '0) + tprod;
                end
                r_k <= r_k + 2'd1;
            end
            chbs_pkg::BK_VERT0: r_acc <= ACC_W'(r_h0) * ACC_W'(gy);
            chbs_pkg::BK_VERT1: r_height <= vsum[chbs_pkg::RES_LSB +: 8];
            default: ;
        endcase
    end

    assign o_res.height      = r_height;
    assign o_res.bad_request = r_bad;

    `CHBS_ASSERT_IMP(a_offs_bound, r_state == chbs_pkg::BK_OFFS, r_lvl <= r_level, "mip offset walk passed the requested level")
    `CHBS_ASSERT_IMP(a_ptr_bound, 1'b1, 32'(r_ptr) <= 32'(STORE_DEPTH), "load pointer beyond texel store")
    `CHBS_ASSERT_NXT(a_fetch_done, (r_state == chbs_pkg::BK_ACC) && (r_k == 2'd3), r_state == chbs_pkg::BK_VERT0, "fourth texel did not start the blend")

endmodule

// ===== rtl/cube_heightmap_bilinear_sampler.sv =====
// Channel   Dir  Handshake      Payload
// item      in   push / full    i_kind i_texel_byte i_load_start i_face i_level i_u_coord i_v_coord
// result    out  pop / empty    o_height o_bad_request
// config    in   i_cfg_we       i_cfg_idx i_cfg_data
//
// A load is written to texel memory from the idle state; a bad request passes through the done state.
// A sample walks the mip offsets one level per cycle, then each of the four texel fetches passes
// through the address, read and accumulate states on the single texel memory read port.
// Items enter a two-entry command queue, so the front keeps accepting while the back works until it is full;
// a full result queue stalls only the back end.
// Reset clears the queues, the load pointer and the configuration (64 x 64, seven levels);
// texel memory is not cleared.
module cube_heightmap_bilinear_sampler #(
    parameter int MAX_SIDE    = chbs_pkg::MAX_SIDE_DEF,
    parameter int MAX_LEVELS  = chbs_pkg::MAX_LEVELS_DEF,
    parameter int STORE_DEPTH = chbs_pkg::STORE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [chbs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [chbs_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_kind,
    input  logic [7:0]                     i_texel_byte,
    input  logic                           i_load_start,
    input  logic [2:0]                     i_face,
    input  logic [2:0]                     i_level,
    input  logic [chbs_pkg::COORD_W-1:0]   i_u_coord,
    input  logic [chbs_pkg::COORD_W-1:0]   i_v_coord,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     o_height,
    output logic                           o_bad_request
);

    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CMD_W = $bits(chbs_pkg::t_cmd);
    localparam int RES_W = $bits(chbs_pkg::t_res);

    chbs_pkg::t_cmd   front_cmd, back_cmd;
    chbs_pkg::t_res   back_res, out_res;
    logic [CMD_W-1:0] cmd_q_data;
    logic [RES_W-1:0] res_q_data;
    logic             cmd_push, cmd_empty, cmd_pop;
    logic             res_push, res_full;
    logic [SW-1:0]    width, height;

    chbs_front #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .i_q_full     (full),
        .i_kind       (i_kind),
        .i_texel_byte (i_texel_byte),
        .i_load_start (i_load_start),
        .i_face       (i_face),
        .i_level      (i_level),
        .i_u_coord    (i_u_coord),
        .i_v_coord    (i_v_coord),
        .o_q_push     (cmd_push),
        .o_cmd        (front_cmd),
        .o_width      (width),
        .o_height     (height)
    );

    chbs_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (chbs_pkg::CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_q_data),
        .o_empty (cmd_empty)
    );

    assign back_cmd = chbs_pkg::t_cmd'(cmd_q_data);

    chbs_back #(
        .MAX_SIDE    (MAX_SIDE),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (width),
        .i_height    (height),
        .i_cmd       (back_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    chbs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (chbs_pkg::RES_Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q_data),
        .o_empty (empty)
    );

    assign out_res       = chbs_pkg::t_res'(res_q_data);
    assign o_height      = out_res.height;
    assign o_bad_request = out_res.bad_request;

endmodule
